// File: design/ttps_pkg.sv
// Shared types and constants for the transposition table probe/store block.
package ttps_pkg;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 16;
    localparam int KIND_W  = 2;

    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CUT   = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [DEPTH_W-1:0] depth;
        logic [SCORE_W-1:0] score;
        logic [KIND_W-1:0]  kind;
    } t_entry;

endpackage

// File: design/transposition_table_probe_store_core.sv
// Direct-mapped always-replace transposition table with one entry memory.
//
// Each transaction addresses one entry by the low log2(TABLE_ENTRIES) bits of the
// key; TABLE_ENTRIES must be a power of two. The block takes one transaction per
// clock cycle while o_in_stall is low. A store writes its entry at the edge it is
// accepted and gives no result. A probe reads the entry memory at the edge it is
// accepted; the probe stage then passes its result to the result register,
// raising o_out_valid, once that register is empty or i_out_stall is low. Because
// the store writes at acceptance, a probe that follows a store to the same entry
// in the next cycle already reads the new contents. After reset the block runs a
// clearing pass over the single write port of the entry memory, one entry per
// cycle. It holds o_in_stall high and accepts nothing until all are cleared.
module transposition_table_probe_store_core #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_cmd,
    input  logic [ttps_pkg::KEY_W-1:0]         i_hash_key,
    input  logic [ttps_pkg::DEPTH_W-1:0]       i_search_depth,
    input  logic signed [ttps_pkg::SCORE_W-1:0] i_store_score,
    input  logic [ttps_pkg::KIND_W-1:0]        i_node_kind,
    input  logic signed [ttps_pkg::SCORE_W-1:0] i_window_low,
    input  logic signed [ttps_pkg::SCORE_W-1:0] i_window_high,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_hit,
    output logic signed [ttps_pkg::SCORE_W-1:0] o_probe_score
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    ttps_pkg::t_entry r_mem [TABLE_ENTRIES];
    ttps_pkg::t_entry r_rd;

    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_addr;

    logic                               r_p1_valid;
    logic [ttps_pkg::KEY_W-1:0]         r_p1_key;
    logic [ttps_pkg::DEPTH_W-1:0]       r_p1_depth;
    logic signed [ttps_pkg::SCORE_W-1:0] r_p1_alpha;
    logic signed [ttps_pkg::SCORE_W-1:0] r_p1_beta;

    logic                               r_out_valid;
    logic                               r_hit;
    logic signed [ttps_pkg::SCORE_W-1:0] r_score;

    logic                               in_accept;
    logic                               can_move;
    logic [IDX_W-1:0]                   idx;
    logic                               wr_en;
    logic [IDX_W-1:0]                   wr_addr;
    ttps_pkg::t_entry                   wr_data;
    logic                               n_hit;
    logic signed [ttps_pkg::SCORE_W-1:0] n_score;
    logic signed [ttps_pkg::SCORE_W-1:0] rd_score;
    logic                               entry_match;

    assign idx        = i_hash_key[IDX_W-1:0];
    assign can_move   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_clearing || (r_p1_valid && !can_move);
    assign in_accept  = i_in_valid && !o_in_stall;

    // The clearing pass and stores share the single write port.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx;
        wr_data = '{valid: 1'b1, key: i_hash_key, depth: i_search_depth,
                    score: i_store_score, kind: i_node_kind};
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (in_accept && i_cmd == ttps_pkg::CMD_STORE) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (in_accept && i_cmd == ttps_pkg::CMD_PROBE) begin
            r_rd <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (r_clr_addr == LAST_IDX) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Probe stage: captures the request while the entry is read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (in_accept) begin
            r_p1_valid <= (i_cmd == ttps_pkg::CMD_PROBE);
        end else if (can_move) begin
            r_p1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_cmd == ttps_pkg::CMD_PROBE) begin
            r_p1_key   <= i_hash_key;
            r_p1_depth <= i_search_depth;
            r_p1_alpha <= i_window_low;
            r_p1_beta  <= i_window_high;
        end
    end

    assign rd_score    = $signed(r_rd.score);
    assign entry_match = r_rd.valid && (r_rd.key == r_p1_key) && (r_rd.depth >= r_p1_depth);

    always_comb begin
        n_hit   = 1'b0;
        n_score = '0;
        if (entry_match) begin
            case (r_rd.kind)
                ttps_pkg::KIND_EXACT: begin
                    n_hit   = 1'b1;
                    n_score = rd_score;
                end
                ttps_pkg::KIND_ALL: begin
                    if (rd_score <= r_p1_alpha) begin
                        n_hit   = 1'b1;
                        n_score = r_p1_alpha;
                    end
                end
                ttps_pkg::KIND_CUT: begin
                    if (rd_score >= r_p1_beta) begin
                        n_hit   = 1'b1;
                        n_score = r_p1_beta;
                    end
                end
                default: begin
                    n_hit   = 1'b0;
                    n_score = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_move) begin
            r_out_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_move && r_p1_valid) begin
            r_hit   <= n_hit;
            r_score <= n_score;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_probe_score = r_score;

endmodule

// File: design/ttps_checker.sv
// Port-level checker for the transposition table core, bound into the core module.
module ttps_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               i_cmd,
    input logic [ttps_pkg::KEY_W-1:0]         i_hash_key,
    input logic [ttps_pkg::DEPTH_W-1:0]       i_search_depth,
    input logic signed [ttps_pkg::SCORE_W-1:0] i_store_score,
    input logic [ttps_pkg::KIND_W-1:0]        i_node_kind,
    input logic signed [ttps_pkg::SCORE_W-1:0] i_window_low,
    input logic signed [ttps_pkg::SCORE_W-1:0] i_window_high,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_hit,
    input logic signed [ttps_pkg::SCORE_W-1:0] o_probe_score
);

    // A stalled input transaction keeps its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_cmd)
                                        && $stable(i_hash_key) && $stable(i_search_depth)
                                        && $stable(i_store_score) && $stable(i_node_kind)
                                        && $stable(i_window_low) && $stable(i_window_high)))
        else $error("input changed while stalled");

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_hit)
                                          && $stable(o_probe_score)))
        else $error("result changed while stalled");

    // A miss always reports a zero score.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_probe_score == '0))
        else $error("miss with nonzero score");

    // Reset empties the result register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // The clearing pass after reset blocks new transactions.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input accepted during clearing pass");

endmodule

bind transposition_table_probe_store_core ttps_checker u_ttps_checker (.*);
